### sv/spe_pkg.sv
// spe_pkg: widths, register indexes, reset values and spectrum breakpoints
// for the spectral palette entry block. Depends on nothing.
`default_nettype none

package spe_pkg;

  // default cap on the colour count
  localparam int unsigned DEF_MAX_COLOURS = 4096;

  // field and register widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned NM_W       = 10;
  localparam int unsigned LOW_W      = 9;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CNT_MAX    = 2 ** CNT_W - 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // wavelength in nm with 8 fraction bits
  localparam int unsigned WL_FRAC    = 8;
  localparam int unsigned WL_W       = NM_W + WL_FRAC;
  localparam int unsigned NUM_W      = NM_W + CNT_W;

  // colour and intensity fractions, channel divide
  localparam int unsigned CN_W       = 17;
  localparam int unsigned CD_W       = 15;
  localparam int unsigned SN_W       = 20;
  localparam int unsigned CH_DEN_W   = 30;
  localparam int unsigned CH_NUM_W   = CH_DEN_W + CH_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_HIGH    = 3'd4;

  // register reset values
  localparam logic [CNT_W-1:0] RST_COLOUR_COUNT = 13'd256;
  localparam logic [NM_W-1:0]  RST_SWEEP_START  = 10'd350;
  localparam logic [NM_W-1:0]  RST_SWEEP_END    = 10'd780;
  localparam logic [LOW_W-1:0] RST_SPAN_LOW     = 9'd350;
  localparam logic [NM_W-1:0]  RST_SPAN_HIGH    = 10'd780;

  // spectrum breakpoints, Q.8 nm
  localparam logic [WL_W-1:0] WL_320 = 18'(320 * 256);
  localparam logic [WL_W-1:0] WL_420 = 18'(420 * 256);
  localparam logic [WL_W-1:0] WL_440 = 18'(440 * 256);
  localparam logic [WL_W-1:0] WL_490 = 18'(490 * 256);
  localparam logic [WL_W-1:0] WL_510 = 18'(510 * 256);
  localparam logic [WL_W-1:0] WL_580 = 18'(580 * 256);
  localparam logic [WL_W-1:0] WL_645 = 18'(645 * 256);
  localparam logic [WL_W-1:0] WL_700 = 18'(700 * 256);
  localparam logic [NM_W-1:0] NM_700 = 10'd700;

  // segment widths as colour denominators, Q.8 nm
  localparam logic [CD_W-1:0] CD_VIOLET = 15'(90 * 256);
  localparam logic [CD_W-1:0] CD_BLUE   = 15'(50 * 256);
  localparam logic [CD_W-1:0] CD_CYAN   = 15'(20 * 256);
  localparam logic [CD_W-1:0] CD_GREEN  = 15'(70 * 256);
  localparam logic [CD_W-1:0] CD_YELLOW = 15'(65 * 256);

  // rising intensity runs from zero at 320 nm to one at 420 nm
  localparam logic [SN_W-1:0] SD_RISE   = 20'(100 * 256);

endpackage

`default_nettype wire

### sv/spe_div_pipe.sv
// spe_div_pipe: pipelined restoring divider, one quotient bit per stage,
// several lanes sharing one divisor. Stand-alone, no package needed.
`default_nettype none

module spe_div_pipe #(
  parameter int unsigned LANES = 1,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned QUO_W = 8,
  parameter int unsigned TAG_W = 1,
  localparam int unsigned NUM_W = DEN_W + QUO_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [TAG_W-1:0]             tag_i,
  input  logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]             den_i,
  output logic                         valid_o,
  output logic [TAG_W-1:0]             tag_o,
  output logic [LANES-1:0][QUO_W-1:0]  quo_o
);

  // the upper DEN_W bits of a dividend are expected below the divisor

  logic [QUO_W-1:0]                 vld_q;
  logic [TAG_W-1:0]                 tag_q   [QUO_W];
  logic [DEN_W-1:0]                 den_q   [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      rem_q   [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      rem_d   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      low_q   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      low_d   [QUO_W];
  logic [TAG_W-1:0]                 src_tag [QUO_W];
  logic [DEN_W-1:0]                 src_den [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      src_rem [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      src_low [QUO_W];

  // stage sources: ports for the first stage, previous stage after that
  always_comb begin
    src_tag[0] = tag_i;
    src_den[0] = den_i;
    for (int l = 0; l < LANES; l++) begin
      src_rem[0][l] = num_i[l][NUM_W-1:QUO_W];
      src_low[0][l] = num_i[l][QUO_W-1:0];
    end
    for (int k = 1; k < QUO_W; k++) begin
      src_tag[k] = tag_q[k-1];
      src_den[k] = den_q[k-1];
      src_rem[k] = rem_q[k-1];
      src_low[k] = low_q[k-1];
    end
  end

  // one restoring step per stage: bring down a bit, subtract if it fits,
  // quotient bits shift in where dividend bits leave
  always_comb begin
    logic [DEN_W:0] cat;
    logic [DEN_W:0] dif;
    logic           ge;
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        cat = {src_rem[k][l], src_low[k][l][QUO_W-1]};
        dif = cat - {1'b0, src_den[k]};
        ge  = (cat >= {1'b0, src_den[k]});
        rem_d[k][l] = ge ? dif[DEN_W-1:0] : cat[DEN_W-1:0];
        low_d[k][l] = {src_low[k][l][QUO_W-2:0], ge};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QUO_W; k++) begin
      tag_q[k] <= src_tag[k];
      den_q[k] <= src_den[k];
      rem_q[k] <= rem_d[k];
      low_q[k] <= low_d[k];
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];
  assign quo_o   = low_q[QUO_W-1];

  // every valid quotient belongs to a valid dividend taken in at the ports
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, QUO_W))
    else $error("divider output without matching input");

endmodule

`default_nettype wire

### sv/spectrum_palette_entry_top.sv
// spectrum_palette_entry_top: spectral palette entry, index to 8-bit RGB.
// Depends on spe_pkg and spe_div_pipe.
`default_nettype none

// The block takes one palette index in every clock cycle: busy is never
// raised, so a word is accepted whenever start is high. Each word gives one
// result, shown on red_o, green_o and blue_o for one cycle with done_o high,
// in input order. The pipeline is built around the two restoring dividers,
// one quotient bit per stage: an 18-stage divider forms the Q.8 wavelength
// from the colour count, an 8-stage divider forms the three channel values,
// with seven further register stages for the index, the products, the
// spectrum lookup and the output. The receiver cannot hold results off and
// none is needed. Registers must be written through cfg_we_i only while no
// index is in flight; the block itself does not enforce this.

module spectrum_palette_entry_top
  import spe_pkg::*;
#(
  parameter int unsigned MAX_COLOURS = DEF_MAX_COLOURS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      palette_index_i,
  output logic                  done_o,
  output logic [CH_W-1:0]       red_o,
  output logic [CH_W-1:0]       green_o,
  output logic [CH_W-1:0]       blue_o
);

  localparam int unsigned CNT_CAP = (MAX_COLOURS < CNT_MAX) ? MAX_COLOURS : CNT_MAX;
  localparam int unsigned LATENCY = 3 + WL_W + 3 + CH_W + 1;

  // configuration registers
  logic [CNT_W-1:0] colour_count_q;
  logic [NM_W-1:0]  sweep_start_q;
  logic [NM_W-1:0]  sweep_end_q;
  logic [LOW_W-1:0] span_low_q;
  logic [NM_W-1:0]  span_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_count_q <= RST_COLOUR_COUNT;
      sweep_start_q  <= RST_SWEEP_START;
      sweep_end_q    <= RST_SWEEP_END;
      span_low_q     <= RST_SPAN_LOW;
      span_high_q    <= RST_SPAN_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOUR_COUNT: colour_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_SWEEP_START:  sweep_start_q  <= cfg_data_i[NM_W-1:0];
        CFG_SWEEP_END:    sweep_end_q    <= cfg_data_i[NM_W-1:0];
        CFG_SPAN_LOW:     span_low_q     <= cfg_data_i[LOW_W-1:0];
        CFG_SPAN_HIGH:    span_high_q    <= cfg_data_i[NM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective colour count, capped
  logic [CNT_W-1:0] cnt;
  assign cnt  = (colour_count_q > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : colour_count_q;
  assign busy = 1'b0;

  // stage 1: capture the index
  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= palette_index_i;
  end

  // stage 2: sweep products and the black test for the last entries
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] rest;
  logic [NUM_W-1:0] pa_d;
  logic [NUM_W-2:0] pb_d;
  logic             black_d;

  assign idx_ext = {1'b0, s1_idx_q};
  assign idx_p1  = idx_ext + CNT_W'(1);
  assign rest    = cnt - idx_ext;
  assign pa_d    = NUM_W'(sweep_start_q) * NUM_W'(rest);
  assign pb_d    = (NUM_W-1)'(s1_idx_q) * (NUM_W-1)'(sweep_end_q);
  assign black_d = (cnt == '0) || (idx_p1 >= cnt);

  logic             s2_vld_q;
  logic [NUM_W-1:0] s2_pa_q;
  logic [NUM_W-2:0] s2_pb_q;
  logic             s2_black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pa_q    <= pa_d;
    s2_pb_q    <= pb_d;
    s2_black_q <= black_d;
  end

  // stage 3: count times wavelength in nm
  logic             s3_vld_q;
  logic [NUM_W-1:0] s3_num_q;
  logic             s3_black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_num_q   <= s2_pa_q + {1'b0, s2_pb_q};
    s3_black_q <= s2_black_q;
  end

  // wavelength divider: Q.8 nm = 256 * sum / count
  logic [0:0][NUM_W+WL_FRAC-1:0] wd_num;
  logic                          wd_vld;
  logic                          wd_black;
  logic [0:0][WL_W-1:0]          wd_quo;

  assign wd_num[0] = {s3_num_q, WL_FRAC'(0)};

  spe_div_pipe #(
    .LANES (1),
    .DEN_W (CNT_W),
    .QUO_W (WL_W),
    .TAG_W (1)
  ) u_wl_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .tag_i   (s3_black_q),
    .num_i   (wd_num),
    .den_i   (cnt),
    .valid_o (wd_vld),
    .tag_o   (wd_black),
    .quo_o   (wd_quo)
  );

  // stage 4: spectrum segment and intensity as fractions
  logic [WL_W-1:0]           w;
  logic [WL_W-1:0]           lo;
  logic [WL_W-1:0]           hi;
  logic [NM_W-1:0]           hdiff;
  logic [CN_W-1:0]           span;
  logic [2:0][CN_W-1:0]      cn_d;
  logic [CD_W-1:0]           cd_d;
  logic [SN_W-1:0]           sn_d;
  logic [SN_W-1:0]           sd_d;

  assign w     = wd_quo[0];
  assign lo    = {1'b0, span_low_q, WL_FRAC'(0)};
  assign hi    = {span_high_q, WL_FRAC'(0)};
  assign hdiff = span_high_q - NM_700;
  assign span  = {hdiff[CN_W-WL_FRAC-1:0], WL_FRAC'(0)};

  // six-segment colour, lane 0 red, 1 green, 2 blue
  always_comb begin
    cd_d = CD_W'(1);
    cn_d = '0;
    if (w >= lo && w < WL_440) begin
      cd_d    = CD_VIOLET;
      cn_d[0] = CN_W'(WL_440 - w);
      cn_d[2] = CN_W'(CD_VIOLET);
    end else if (w >= WL_440 && w < WL_490) begin
      cd_d    = CD_BLUE;
      cn_d[1] = CN_W'(w - WL_440);
      cn_d[2] = CN_W'(CD_BLUE);
    end else if (w >= WL_490 && w < WL_510) begin
      cd_d    = CD_CYAN;
      cn_d[1] = CN_W'(CD_CYAN);
      cn_d[2] = CN_W'(WL_510 - w);
    end else if (w >= WL_510 && w < WL_580) begin
      cd_d    = CD_GREEN;
      cn_d[0] = CN_W'(w - WL_510);
      cn_d[1] = CN_W'(CD_GREEN);
    end else if (w >= WL_580 && w < WL_645) begin
      cd_d    = CD_YELLOW;
      cn_d[0] = CN_W'(CD_YELLOW);
      cn_d[1] = CN_W'(WL_645 - w);
    end else if (w >= WL_645 && w <= hi) begin
      cd_d    = CD_W'(1);
      cn_d[0] = CN_W'(1);
    end
  end

  // intensity: rising below 420 nm, flat, falling above 700 nm
  always_comb begin
    logic [WL_W-1:0] hmw;
    logic [SN_W:0]   hmw7;
    logic [SN_W-1:0] three_s;
    hmw     = hi - w;
    hmw7    = {hmw, 3'b000} - {3'b000, hmw};
    three_s = {2'b00, span, 1'b0} + {3'b000, span};
    sd_d    = SN_W'(1);
    sn_d    = '0;
    if (w >= lo && w < WL_420) begin
      sd_d = SD_RISE;
      sn_d = (w >= WL_320) ? SN_W'(w - WL_320) : '0;
    end else if (w >= WL_420 && w <= WL_700) begin
      sn_d = SN_W'(1);
    end else if (w > WL_700 && w <= hi) begin
      sd_d = {span, 3'b000} + {2'b00, span, 1'b0};
      sn_d = three_s + hmw7[SN_W-1:0];
    end
  end

  logic                 s4_vld_q;
  logic                 s4_black_q;
  logic [2:0][CN_W-1:0] s4_cn_q;
  logic [CD_W-1:0]      s4_cd_q;
  logic [SN_W-1:0]      s4_sn_q;
  logic [SN_W-1:0]      s4_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= wd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_black_q <= wd_black;
    s4_cn_q    <= cn_d;
    s4_cd_q    <= cd_d;
    s4_sn_q    <= sn_d;
    s4_sd_q    <= sd_d;
  end

  // stage 5: numerator and denominator products, all within 30 bits
  logic [2:0][CH_DEN_W-1:0] p_d;
  logic [CH_DEN_W-1:0]      den_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p_d[l] = CH_DEN_W'(s4_sn_q) * CH_DEN_W'(s4_cn_q[l]);
    end
    den_d = CH_DEN_W'(s4_sd_q) * CH_DEN_W'(s4_cd_q);
  end

  logic                     s5_vld_q;
  logic                     s5_black_q;
  logic [2:0][CH_DEN_W-1:0] s5_p_q;
  logic [CH_DEN_W-1:0]      s5_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_black_q <= s4_black_q;
    s5_p_q     <= p_d;
    s5_den_q   <= den_d;
  end

  // stage 6: scale numerators by 255
  logic                     s6_vld_q;
  logic                     s6_black_q;
  logic [2:0][CH_NUM_W-1:0] s6_n_q;
  logic [CH_DEN_W-1:0]      s6_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      s6_n_q[l] <= {s5_p_q[l], CH_W'(0)} - {CH_W'(0), s5_p_q[l]};
    end
    s6_black_q <= s5_black_q;
    s6_den_q   <= s5_den_q;
  end

  // channel divider, three lanes on one denominator
  logic                 cd_vld;
  logic                 cd_black;
  logic [2:0][CH_W-1:0] cd_quo;

  spe_div_pipe #(
    .LANES (3),
    .DEN_W (CH_DEN_W),
    .QUO_W (CH_W),
    .TAG_W (1)
  ) u_ch_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .tag_i   (s6_black_q),
    .num_i   (s6_n_q),
    .den_i   (s6_den_q),
    .valid_o (cd_vld),
    .tag_o   (cd_black),
    .quo_o   (cd_quo)
  );

  // output register, last entries forced to black
  logic            done_q;
  logic [CH_W-1:0] red_q;
  logic [CH_W-1:0] green_q;
  logic [CH_W-1:0] blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= cd_black ? '0 : cd_quo[0];
    green_q <= cd_black ? '0 : cd_quo[1];
    blue_q  <= cd_black ? '0 : cd_quo[2];
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // every accepted word comes out with done_o high
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted word lost in pipeline");

  // no result without an accepted word behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  // intensity never above one, so the channel quotient fits eight bits
  a_intensity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> (s4_sn_q <= s4_sd_q))
    else $error("intensity fraction above one");

endmodule

`default_nettype wire
